// File: rtl/lebe_pkg.sv
// Shared types and constants for the line edit buffer engine.
// No dependencies; every other file imports this package.
`default_nettype none

package lebe_pkg;

    // Field widths fixed by the item format
    localparam int POS_W = 8;
    localparam int CAP_W = 9;
    localparam int KEY_W = 16;
    localparam int CHR_W = 8;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [CAP_W-1:0] cap_t;
    typedef logic [KEY_W-1:0] key_t;
    typedef logic [CHR_W-1:0] chr_t;

    // Capacity after reset
    localparam cap_t CAP_RESET = 9'd256;

    // Printable key window: KEY_FIRST <= key < KEY_END
    localparam key_t KEY_FIRST = 16'd32;
    localparam key_t KEY_END   = 16'd127;

    // Edit op codes
    typedef enum logic [3:0] {
        OP_INSERT    = 4'd0,
        OP_BACKSPACE = 4'd1,
        OP_DELETE    = 4'd2,
        OP_LEFT      = 4'd3,
        OP_RIGHT     = 4'd4,
        OP_SET_CUR   = 4'd5,
        OP_SET_SEL   = 4'd6,
        OP_SEL_ALL   = 4'd7,
        OP_SEL_CLR   = 4'd8,
        OP_CLEAR     = 4'd9,
        OP_READ      = 4'd10
    } op_t;

    // Controller sequence states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SHIFT_DN,
        ST_SHIFT_UP,
        ST_READ_WAIT,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// File: rtl/lebe_if.sv
// Channel interfaces: edit request, edit response and capacity write.
// Depends on lebe_pkg for the field types.
`default_nettype none

interface lebe_req_if;
    import lebe_pkg::*;
    logic       valid;
    logic       ready;
    logic [3:0] op;
    key_t       key;
    pos_t       pos_a;
    pos_t       pos_b;

    modport source (output valid, output op, output key, output pos_a, output pos_b,
                    input ready);
    modport sink   (input valid, input op, input key, input pos_a, input pos_b,
                    output ready);
endinterface

interface lebe_rsp_if;
    import lebe_pkg::*;
    logic valid;
    logic ready;
    logic changed;
    pos_t text_length;
    pos_t cursor_pos;
    pos_t sel_low;
    pos_t sel_high;
    chr_t char_out;

    modport source (output valid, output changed, output text_length, output cursor_pos,
                    output sel_low, output sel_high, output char_out, input ready);
    modport sink   (input valid, input changed, input text_length, input cursor_pos,
                    input sel_low, input sel_high, input char_out, output ready);
endinterface

interface lebe_cfg_if;
    import lebe_pkg::*;
    logic valid;
    logic ready;
    cap_t capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

`default_nettype wire

// File: rtl/line_edit_buffer_engine.sv
// Top level of the line edit buffer engine: capacity register, sequencer, store.
// Depends on lebe_pkg, lebe_if, lebe_mem and lebe_ctrl.
`default_nettype none

// Each request transaction carries one edit op and yields exactly one response
// transaction. Backspace and delete move one character per cycle through the
// store's single read and write port; an insert that replaces a selection first
// closes the gap and then opens a slot. The next request is taken as soon as
// the response register is loaded, even while that response still waits to be
// taken. The capacity register is written through its own channel, which is
// always ready; write it only while no edit is in flight.
// The store is not cleared at reset: reads past the length return 0.
module line_edit_buffer_engine #(
    parameter int STORE_DEPTH = 256
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lebe_req_if.sink  req,
    lebe_rsp_if.source rsp,
    lebe_cfg_if.sink  cfg
);
    import lebe_pkg::*;

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    cap_t          cap_reg, cap_next;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    chr_t          mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    chr_t          mem_rdata;

    // Capacity register write
    assign cfg.ready = 1'b1;
    assign cap_next  = cfg.valid ? cfg.capacity : cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    lebe_ctrl #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .capacity  (cap_reg),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    lebe_mem #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// File: rtl/lebe_mem.sv
// Character store: one write port, one read port, registered read data.
// Depends on lebe_pkg for the character type.
`default_nettype none

module lebe_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic           clk,
    input  wire logic           we,
    input  wire logic [AW-1:0]  waddr,
    input  wire lebe_pkg::chr_t wdata,
    input  wire logic           re,
    input  wire logic [AW-1:0]  raddr,
    output lebe_pkg::chr_t      rdata
);
    import lebe_pkg::*;

    chr_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/lebe_ctrl.sv
// Edit sequencer: holds length, cursor and anchors, runs the store shifts
// and owns the response register. Depends on lebe_pkg and lebe_if.
`default_nettype none

module lebe_ctrl #(
    parameter int STORE_DEPTH = 256,
    parameter int AW          = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    lebe_req_if.sink            req,
    lebe_rsp_if.source          rsp,
    input  wire lebe_pkg::cap_t capacity,
    output logic                mem_we,
    output logic [AW-1:0]       mem_waddr,
    output lebe_pkg::chr_t      mem_wdata,
    output logic                mem_re,
    output logic [AW-1:0]       mem_raddr,
    input  wire lebe_pkg::chr_t mem_rdata
);
    import lebe_pkg::*;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    key_t   key_reg, key_next;
    pos_t   pa_reg, pa_next;
    pos_t   pb_reg, pb_next;

    // Text positions are capacity wide so any length below capacity fits
    cap_t   len_reg, len_next;
    cap_t   cur_reg, cur_next;
    cap_t   ast_reg, ast_next;
    cap_t   aen_reg, aen_next;

    logic   chg_reg, chg_next;
    chr_t   ch_reg, ch_next;
    logic   ins_reg, ins_next;
    cap_t   base_reg, base_next;
    cap_t   gap_reg, gap_next;
    cap_t   src_reg, src_next;
    cap_t   wa_reg, wa_next;
    logic   pend_reg, pend_next;

    logic   ov_reg, ov_next;
    logic   o_chg_reg;
    pos_t   o_len_reg, o_cur_reg, o_lo_reg, o_hi_reg;
    chr_t   o_ch_reg;

    cap_t   sel_lo, sel_hi, sel_gap;
    logic   sel_any;
    logic   key_ok, fits;
    cap_t   need;
    cap_t   clamp_a, clamp_b;
    logic   out_free;
    logic   load_out;

    // Selection bounds and insert admission
    always_comb
    begin
        sel_lo  = (ast_reg < aen_reg) ? ast_reg : aen_reg;
        sel_hi  = (ast_reg > aen_reg) ? ast_reg : aen_reg;
        sel_gap = sel_hi - sel_lo;
        sel_any = (ast_reg != aen_reg);
        key_ok  = (key_reg >= KEY_FIRST) && (key_reg < KEY_END);
        need    = len_reg - sel_gap + cap_t'(1);
        fits    = (need < capacity) && (32'(need) < 32'(STORE_DEPTH));
        clamp_a = (cap_t'(pa_reg) > len_reg) ? len_reg : cap_t'(pa_reg);
        clamp_b = (cap_t'(pb_reg) > len_reg) ? len_reg : cap_t'(pb_reg);
    end

    assign out_free  = !ov_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);

    // Next state and datapath control
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        len_next   = len_reg;
        cur_next   = cur_reg;
        ast_next   = ast_reg;
        aen_next   = aen_reg;
        chg_next   = chg_reg;
        ch_next    = ch_reg;
        ins_next   = ins_reg;
        base_next  = base_reg;
        gap_next   = gap_reg;
        src_next   = src_reg;
        wa_next    = wa_reg;
        pend_next  = pend_reg;
        load_out   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = op_t'(req.op);
                    key_next   = req.key;
                    pa_next    = req.pos_a;
                    pb_next    = req.pos_b;
                    chg_next   = 1'b0;
                    ch_next    = '0;
                    ins_next   = 1'b0;
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                state_next = ST_FINISH;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (key_ok && fits)
                        begin
                            ins_next  = 1'b1;
                            pend_next = 1'b0;
                            if (sel_any)
                            begin
                                base_next  = sel_lo;
                                gap_next   = sel_gap;
                                src_next   = sel_hi;
                                state_next = ST_SHIFT_DN;
                            end
                            else
                            begin
                                src_next   = len_reg;
                                state_next = ST_SHIFT_UP;
                            end
                        end
                    end
                    OP_BACKSPACE:
                    begin
                        pend_next = 1'b0;
                        if (sel_any)
                        begin
                            base_next  = sel_lo;
                            gap_next   = sel_gap;
                            src_next   = sel_hi;
                            state_next = ST_SHIFT_DN;
                        end
                        else if (cur_reg != '0)
                        begin
                            base_next  = cur_reg - cap_t'(1);
                            gap_next   = cap_t'(1);
                            src_next   = cur_reg;
                            state_next = ST_SHIFT_DN;
                        end
                    end
                    OP_DELETE:
                    begin
                        pend_next = 1'b0;
                        if (sel_any)
                        begin
                            base_next  = sel_lo;
                            gap_next   = sel_gap;
                            src_next   = sel_hi;
                            state_next = ST_SHIFT_DN;
                        end
                        else if (cur_reg < len_reg)
                        begin
                            base_next  = cur_reg;
                            gap_next   = cap_t'(1);
                            src_next   = cur_reg + cap_t'(1);
                            state_next = ST_SHIFT_DN;
                        end
                    end
                    OP_LEFT:
                    begin
                        if (sel_any)
                        begin
                            cur_next = sel_lo;
                            ast_next = sel_lo;
                            aen_next = sel_lo;
                            chg_next = 1'b1;
                        end
                        else if (cur_reg != '0)
                        begin
                            cur_next = cur_reg - cap_t'(1);
                            ast_next = cur_reg - cap_t'(1);
                            aen_next = cur_reg - cap_t'(1);
                            chg_next = 1'b1;
                        end
                    end
                    OP_RIGHT:
                    begin
                        if (sel_any)
                        begin
                            cur_next = sel_hi;
                            ast_next = sel_hi;
                            aen_next = sel_hi;
                            chg_next = 1'b1;
                        end
                        else if (cur_reg < len_reg)
                        begin
                            cur_next = cur_reg + cap_t'(1);
                            ast_next = cur_reg + cap_t'(1);
                            aen_next = cur_reg + cap_t'(1);
                            chg_next = 1'b1;
                        end
                    end
                    OP_SET_CUR:
                    begin
                        if (!(cur_reg == clamp_a && !sel_any))
                        begin
                            cur_next = clamp_a;
                            ast_next = clamp_a;
                            aen_next = clamp_a;
                            chg_next = 1'b1;
                        end
                    end
                    OP_SET_SEL:
                    begin
                        if (!(ast_reg == clamp_a && aen_reg == clamp_b && cur_reg == clamp_b))
                        begin
                            ast_next = clamp_a;
                            aen_next = clamp_b;
                            cur_next = clamp_b;
                            chg_next = 1'b1;
                        end
                    end
                    OP_SEL_ALL:
                    begin
                        if (!(ast_reg == '0 && aen_reg == len_reg && cur_reg == len_reg))
                        begin
                            ast_next = '0;
                            aen_next = len_reg;
                            cur_next = len_reg;
                            chg_next = 1'b1;
                        end
                    end
                    OP_SEL_CLR:
                    begin
                        if (sel_any)
                        begin
                            ast_next = cur_reg;
                            aen_next = cur_reg;
                            chg_next = 1'b1;
                        end
                    end
                    OP_CLEAR:
                    begin
                        chg_next = |{len_reg, cur_reg, ast_reg, aen_reg};
                        len_next = '0;
                        cur_next = '0;
                        ast_next = '0;
                        aen_next = '0;
                    end
                    OP_READ:
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = AW'(pa_reg);
                        state_next = ST_READ_WAIT;
                    end
                    default:
                    begin
                        chg_next = 1'b0;
                    end
                endcase
            end

            // Close a gap: store[i] = store[i + gap] walking upward
            ST_SHIFT_DN:
            begin
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(wa_reg);
                    mem_wdata = mem_rdata;
                end
                if (src_reg != len_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(src_reg);
                    wa_next   = src_reg - gap_reg;
                    src_next  = src_reg + cap_t'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        len_next = len_reg - gap_reg;
                        cur_next = base_reg;
                        ast_next = base_reg;
                        aen_next = base_reg;
                        if (ins_reg)
                        begin
                            src_next   = len_reg - gap_reg;
                            state_next = ST_SHIFT_UP;
                        end
                        else
                        begin
                            chg_next   = 1'b1;
                            state_next = ST_FINISH;
                        end
                    end
                end
            end

            // Open a slot at the cursor: store[i] = store[i - 1] walking downward
            ST_SHIFT_UP:
            begin
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(wa_reg);
                    mem_wdata = mem_rdata;
                end
                if (src_reg != cur_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(src_reg - cap_t'(1));
                    wa_next   = src_reg;
                    src_next  = src_reg - cap_t'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = AW'(cur_reg);
                        mem_wdata  = key_reg[CHR_W-1:0];
                        len_next   = len_reg + cap_t'(1);
                        cur_next   = cur_reg + cap_t'(1);
                        ast_next   = cur_reg + cap_t'(1);
                        aen_next   = cur_reg + cap_t'(1);
                        chg_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_READ_WAIT:
            begin
                ch_next    = (cap_t'(pa_reg) < len_reg) ? mem_rdata : '0;
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Response register valid
    always_comb
    begin
        ov_next = ov_reg;
        if (load_out)
        begin
            ov_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            ov_next = 1'b0;
        end
    end

    // Control and edit state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            cur_reg   <= '0;
            ast_reg   <= '0;
            aen_reg   <= '0;
            pend_reg  <= 1'b0;
            ins_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            cur_reg   <= cur_next;
            ast_reg   <= ast_next;
            aen_reg   <= aen_next;
            pend_reg  <= pend_next;
            ins_reg   <= ins_next;
            ov_reg    <= ov_next;
        end
    end

    // Item and shift payload
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        chg_reg  <= chg_next;
        ch_reg   <= ch_next;
        base_reg <= base_next;
        gap_reg  <= gap_next;
        src_reg  <= src_next;
        wa_reg   <= wa_next;
    end

    // Response payload, positions reported modulo 256
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            o_chg_reg <= chg_reg;
            o_len_reg <= len_reg[POS_W-1:0];
            o_cur_reg <= cur_reg[POS_W-1:0];
            o_lo_reg  <= sel_lo[POS_W-1:0];
            o_hi_reg  <= sel_hi[POS_W-1:0];
            o_ch_reg  <= ch_reg;
        end
    end

    assign rsp.valid       = ov_reg;
    assign rsp.changed     = o_chg_reg;
    assign rsp.text_length = o_len_reg;
    assign rsp.cursor_pos  = o_cur_reg;
    assign rsp.sel_low     = o_lo_reg;
    assign rsp.sel_high    = o_hi_reg;
    assign rsp.char_out    = o_ch_reg;

endmodule

`default_nettype wire

// File: rtl/lebe_chk.sv
// Port-level checks on the response channel of the line edit buffer engine,
// bound to the top level. Depends on lebe_pkg.
`default_nettype none

module lebe_chk (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire lebe_pkg::pos_t text_length,
    input wire lebe_pkg::pos_t cursor_pos,
    input wire lebe_pkg::pos_t sel_low,
    input wire lebe_pkg::pos_t sel_high
);
    import lebe_pkg::*;

    // A stalled response stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // A stalled response keeps its payload
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(text_length) && $stable(cursor_pos)
                                    && $stable(sel_low) && $stable(sel_high))
        else $error("response payload moved while stalled");

    // Selection bounds are ordered and within the text
    a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> sel_low <= sel_high && sel_high <= text_length)
        else $error("selection outside the text");

    // Cursor always sits on one end of the selection
    a_cur_anchor: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> cursor_pos == sel_low || cursor_pos == sel_high)
        else $error("cursor detached from selection");

endmodule

bind line_edit_buffer_engine lebe_chk u_lebe_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .text_length (rsp.text_length),
    .cursor_pos  (rsp.cursor_pos),
    .sel_low     (rsp.sel_low),
    .sel_high    (rsp.sel_high)
);

`default_nettype wire

// File: tb/lebe_edit_checker.sv
// Scoreboard for the line edit buffer engine: watches the request, response and
// capacity channels, predicts each response and compares it field by field.
// Depends on lebe_pkg and the channel interfaces in lebe_if.

module lebe_edit_checker
    import lebe_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    lebe_req_if        req,
    lebe_rsp_if        rsp,
    lebe_cfg_if        cfg,
    output int         mismatch_count,
    output int         awaiting
);

    // Printing stops here; counting goes on
    localparam int PRINT_CAP = 60;

    typedef struct packed {
        logic changed;
        pos_t text_length;
        pos_t cursor_pos;
        pos_t sel_low;
        pos_t sel_high;
        chr_t char_out;
    } edit_result_t;

    // Shadow copy of the line and its edit state
    logic [7:0]   line_mem [0:DEPTH-1];
    int           line_len;
    int           caret;
    int           anchor_a;
    int           anchor_b;
    int           cap_reg;
    int           rsp_index;
    edit_result_t pending_results [$];

    function automatic int sel_lo();
        return (anchor_a < anchor_b) ? anchor_a : anchor_b;
    endfunction

    function automatic int sel_hi();
        return (anchor_a > anchor_b) ? anchor_a : anchor_b;
    endfunction

    function automatic void park(input int p);
        caret    = p;
        anchor_a = p;
        anchor_b = p;
    endfunction

    // Remove the selected span and pull the tail down
    function automatic bit cut_selection();
        int lo;
        int gap;
        if (anchor_a == anchor_b)
            return 1'b0;
        lo  = sel_lo();
        gap = sel_hi() - lo;
        for (int i = lo; i + gap < line_len; i++)
            if (i + gap < DEPTH)
                line_mem[i] = line_mem[i + gap];
        line_len -= gap;
        park(lo);
        return 1'b1;
    endfunction

    // Drop one character at index idx
    function automatic void close_at(input int idx);
        for (int i = idx; i + 1 < line_len; i++)
            if (i + 1 < DEPTH)
                line_mem[i] = line_mem[i + 1];
        line_len--;
    endfunction

    function automatic bit pick_range(input int s, input int e);
        if (s > line_len)
            s = line_len;
        if (e > line_len)
            e = line_len;
        if (anchor_a == s && anchor_b == e && caret == e)
            return 1'b0;
        anchor_a = s;
        anchor_b = e;
        caret    = e;
        return 1'b1;
    endfunction

    // Apply one edit to the shadow state and build the response it must give
    function automatic edit_result_t apply_edit(input logic [3:0] op, input key_t key,
                                                input pos_t pa, input pos_t pb);
        edit_result_t res;
        bit           chg;
        int           ch;
        int           lim;
        int           p;
        chg = 1'b0;
        ch  = 0;
        case (op)
            OP_INSERT:
            begin
                lim = (cap_reg < DEPTH) ? cap_reg : DEPTH;
                if (lim != 0 && key >= KEY_FIRST && key < KEY_END &&
                    line_len - (sel_hi() - sel_lo()) + 1 < lim)
                begin
                    void'(cut_selection());
                    for (int i = line_len; i > caret; i--)
                        if (i < DEPTH)
                            line_mem[i] = line_mem[i - 1];
                    if (caret < DEPTH)
                        line_mem[caret] = key[7:0];
                    line_len++;
                    park(caret + 1);
                    chg = 1'b1;
                end
            end
            OP_BACKSPACE:
            begin
                if (cut_selection())
                    chg = 1'b1;
                else if (caret != 0)
                begin
                    close_at(caret - 1);
                    park(caret - 1);
                    chg = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (cut_selection())
                    chg = 1'b1;
                else if (caret < line_len)
                begin
                    close_at(caret);
                    park(caret);
                    chg = 1'b1;
                end
            end
            OP_LEFT:
            begin
                if (anchor_a != anchor_b)
                begin
                    park(sel_lo());
                    chg = 1'b1;
                end
                else if (caret != 0)
                begin
                    park(caret - 1);
                    chg = 1'b1;
                end
            end
            OP_RIGHT:
            begin
                if (anchor_a != anchor_b)
                begin
                    park(sel_hi());
                    chg = 1'b1;
                end
                else if (caret < line_len)
                begin
                    park(caret + 1);
                    chg = 1'b1;
                end
            end
            OP_SET_CUR:
            begin
                p = (int'(pa) > line_len) ? line_len : int'(pa);
                if (!(caret == p && anchor_a == anchor_b))
                begin
                    park(p);
                    chg = 1'b1;
                end
            end
            OP_SET_SEL:
                chg = pick_range(int'(pa), int'(pb));
            OP_SEL_ALL:
                chg = pick_range(0, line_len);
            OP_SEL_CLR:
            begin
                if (anchor_a != anchor_b)
                begin
                    anchor_a = caret;
                    anchor_b = caret;
                    chg = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                chg = (line_len | caret | anchor_a | anchor_b) != 0;
                line_len = 0;
                park(0);
            end
            OP_READ:
            begin
                if (int'(pa) < line_len && int'(pa) < DEPTH)
                    ch = line_mem[pa];
            end
            default:
                ;
        endcase
        res.changed     = chg;
        res.text_length = pos_t'(line_len);
        res.cursor_pos  = pos_t'(caret);
        res.sel_low     = pos_t'(sel_lo());
        res.sel_high    = pos_t'(sel_hi());
        res.char_out    = chr_t'(ch);
        return res;
    endfunction

    task automatic report(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] response %0d: %s", $time, rsp_index, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Per-edge monitor: config, then response compare, then request prediction
    always @(posedge clk or negedge rst_n)
    begin
        edit_result_t want;
        if (!rst_n)
        begin
            line_len       = 0;
            park(0);
            cap_reg        = int'(CAP_RESET);
            rsp_index      = 0;
            mismatch_count = 0;
            pending_results.delete();
            awaiting       = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                cap_reg = int'(cfg.capacity);

            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                    report("response transaction with no request outstanding");
                else
                begin
                    want = pending_results.pop_front();
                    check_field("changed", rsp.changed, want.changed);
                    check_field("text_length", rsp.text_length, want.text_length);
                    check_field("cursor_pos", rsp.cursor_pos, want.cursor_pos);
                    check_field("sel_low", rsp.sel_low, want.sel_low);
                    check_field("sel_high", rsp.sel_high, want.sel_high);
                    check_field("char_out", rsp.char_out, want.char_out);
                end
                rsp_index++;
            end

            if (req.valid && req.ready)
                pending_results.push_back(apply_edit(req.op, req.key, req.pos_a, req.pos_b));

            awaiting = pending_results.size();
        end
    end

endmodule

// File: tb/testbench.sv
// Top of the line edit buffer engine testbench: clock, reset, stimulus and verdict.
// Depends on lebe_pkg, lebe_if, the engine RTL and lebe_edit_checker.

module testbench;
    import lebe_pkg::*;

    localparam int STORE_DEPTH = 256;
    localparam int IDLE_PCT    = 38;
    localparam int STALL_LIMIT = 4000;
    localparam int NUM_PHASES  = 10;
    localparam int CALM_PHASE  = 2;

    localparam logic [3:0] OP_UNUSED_FIRST = 4'd11;
    localparam logic [3:0] OP_UNUSED_LAST  = 4'd15;

    // Random phases: capacity, item count, percent of inserts
    localparam int PHASE_CAP   [NUM_PHASES] = '{256, 8, 511, 0, 1, 2, 300, 64, 3, 256};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{400, 150, 250, 80, 80, 120, 300, 200, 100, 220};
    localparam int PHASE_INS   [NUM_PHASES] = '{75, 40, 50, 50, 50, 50, 60, 60, 50, 45};

    logic clk;
    logic rst_n;
    bit   calm;
    int   mismatch_count;
    int   awaiting;
    int   quiet_cycles;

    lebe_req_if req_ch ();
    lebe_rsp_if rsp_ch ();
    lebe_cfg_if cfg_ch ();

    line_edit_buffer_engine #(
        .STORE_DEPTH (STORE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    lebe_edit_checker #(
        .DEPTH (STORE_DEPTH)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .cfg            (cfg_ch),
        .mismatch_count (mismatch_count),
        .awaiting       (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Response side back-pressure
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: too long without any transaction on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("line_edit_buffer_engine test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One edit request transaction, with random gaps before it
    task automatic send_edit(input logic [3:0] op, input key_t key, input pos_t pa,
                             input pos_t pb);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.key   <= key;
        req_ch.pos_a <= pa;
        req_ch.pos_b <= pb;
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
        @(negedge clk);
    endtask

    task automatic write_capacity(input cap_t value);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.capacity <= value;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Drain: stop requesting and wait for every response to come back
    task automatic wait_idle(input int settle);
        req_ch.valid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic send_random(input int cap, input int ins_pct);
        logic [3:0] op;
        key_t       key;
        pos_t       pa;
        pos_t       pb;
        int         span;
        int         r;
        span = (cap > 255) ? 255 : cap;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            op = OP_INSERT;
        else
        begin
            // Clears are rare so the line can grow to the capacity limit
            r = $urandom_range(0, 99);
            if (r < 1)
                op = OP_CLEAR;
            else if (r < 4)
                op = 4'($urandom_range(int'(OP_UNUSED_FIRST), int'(OP_UNUSED_LAST)));
            else
            begin
                op = 4'($urandom_range(int'(OP_BACKSPACE), int'(OP_READ)));
                if (op == OP_CLEAR)
                    op = OP_READ;
            end
        end
        if ($urandom_range(0, 99) < 85)
            key = key_t'($urandom_range(int'(KEY_FIRST), int'(KEY_END) - 1));
        else
            key = key_t'($urandom_range(0, 65535));
        pa = $urandom_range(0, 1) ? pos_t'($urandom_range(0, 255)) : pos_t'($urandom_range(0, span));
        pb = $urandom_range(0, 1) ? pos_t'($urandom_range(0, 255)) : pos_t'($urandom_range(0, span));
        send_edit(op, key, pa, pb);
    endtask

    initial
    begin
        calm            = 1'b0;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.op       = OP_INSERT;
        req_ch.key      = '0;
        req_ch.pos_a    = '0;
        req_ch.pos_b    = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.capacity = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed edits on an empty line, then a short line
        write_capacity(CAP_RESET);
        send_edit(OP_READ, 16'd0, 8'd0, 8'd0);
        send_edit(OP_UNUSED_LAST, 16'hFFFF, 8'hFF, 8'hFF);
        send_edit(OP_BACKSPACE, 16'd0, 8'd0, 8'd0);
        send_edit(OP_INSERT, 16'd31, 8'd0, 8'd0);
        send_edit(OP_INSERT, 16'd127, 8'd0, 8'd0);
        send_edit(OP_INSERT, 16'hFFFF, 8'd0, 8'd0);
        send_edit(OP_INSERT, 16'd32, 8'd0, 8'd0);
        send_edit(OP_INSERT, 16'd126, 8'd0, 8'd0);
        send_edit(OP_INSERT, 16'd65, 8'd0, 8'd0);
        send_edit(OP_LEFT, 16'd0, 8'd0, 8'd0);
        send_edit(OP_INSERT, 16'd66, 8'd0, 8'd0);
        send_edit(OP_RIGHT, 16'd0, 8'd0, 8'd0);
        send_edit(OP_RIGHT, 16'd0, 8'd0, 8'd0);
        send_edit(OP_SET_CUR, 16'd0, 8'd255, 8'd0);
        send_edit(OP_SET_CUR, 16'd0, 8'd0, 8'd0);
        send_edit(OP_LEFT, 16'd0, 8'd0, 8'd0);
        send_edit(OP_DELETE, 16'd0, 8'd0, 8'd0);
        send_edit(OP_SET_SEL, 16'd0, 8'd255, 8'd1);
        send_edit(OP_INSERT, 16'd67, 8'd0, 8'd0);
        send_edit(OP_SEL_ALL, 16'd0, 8'd0, 8'd0);
        send_edit(OP_READ, 16'd0, 8'd255, 8'd0);
        send_edit(OP_SEL_CLR, 16'd0, 8'd0, 8'd0);
        send_edit(OP_SET_SEL, 16'd0, 8'd0, 8'd1);
        send_edit(OP_BACKSPACE, 16'd0, 8'd0, 8'd0);
        send_edit(OP_READ, 16'd0, 8'd0, 8'd0);
        send_edit(OP_CLEAR, 16'd0, 8'd0, 8'd0);
        send_edit(OP_CLEAR, 16'd0, 8'd0, 8'd0);

        // Random phases, each under its own capacity
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle(6);
            calm = (ph == CALM_PHASE);
            write_capacity(cap_t'(PHASE_CAP[ph]));
            for (int n = 0; n < PHASE_ITEMS[ph]; n++)
                send_random(PHASE_CAP[ph], PHASE_INS[ph]);
        end

        wait_idle(20);
        if (mismatch_count == 0)
            $display("line_edit_buffer_engine test passed");
        else
            $display("line_edit_buffer_engine test failed");
        $finish;
    end

endmodule
